[src/trie_prefix_counter_macros.svh]
// Assertion macros used by the trie prefix counter top level.
`ifndef TRIE_PREFIX_COUNTER_MACROS_SVH
`define TRIE_PREFIX_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define TPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trie prefix counter check failed");

// Next-cycle implication, checked out of reset.
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trie prefix counter check failed");

`else

`define TPC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/tpc_pkg.sv]
// Types and fixed constants of the trie prefix counter.
package tpc_pkg;

  localparam int REQ_W       = 2;
  localparam int LETTER_W    = 5;
  localparam int COUNT_OUT_W = 16;
  localparam int STATUS_W    = 2;
  localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT,
    REQ_EQUAL,
    REQ_PREFIX,
    REQ_ERASE
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_LOST,
    ST_FULL
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHILD,
    S_UPDATE
  } state_t;

  // Counter work for one node, handed from the walk step to the counter bank.
  typedef struct packed {
    logic prefix_inc;
    logic prefix_dec;
    logic end_inc;
    logic end_dec;
    logic sel_end;
    logic sel_prefix;
  } upd_t;

endpackage

[src/trie_prefix_counter.sv]
// Top level of the trie prefix counter: child table, walk control, results.
//
//  channel   signals                          handshake
//  --------  -------------------------------  ---------------------------------
//  request   req_type, letter, word_end       beat taken when start && !busy
//  result    count, status                    beat when done is high, one cycle
//
// Each letter goes through a child table read, then a counter read-modify-write
// on the chosen node. With start held, the next letter is taken while the
// previous letter is in its counter update. done is registered from the
// update step of a word's last letter; the receiver cannot stall, so nothing
// backs up. After rst the child table and the counter memory are swept to
// zero, one entry per cycle, with busy high.
// Walk state (cursor, lost/full flags) returns to the root at every word end.
module trie_prefix_counter #(
  parameter int NODE_COUNT    = 4096,
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_BITS    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [tpc_pkg::REQ_W-1:0]        req_type,
  input  logic [tpc_pkg::LETTER_W-1:0]     letter,
  input  logic                             word_end,
  output logic                             done,
  output logic [tpc_pkg::COUNT_OUT_W-1:0]  count,
  output logic [tpc_pkg::STATUS_W-1:0]     status
);
  import tpc_pkg::*;

  `include "trie_prefix_counter_macros.svh"

  localparam int NODE_BITS = $clog2(NODE_COUNT);
  localparam int SLOTS     = NODE_COUNT * ALPHABET_SIZE;
  localparam int ADDR_W    = $clog2(SLOTS);
  localparam int FREE_W    = NODE_BITS + 1;
  localparam int CMP_W     = 9;   // holds ALPHABET_SIZE up to 511

  // child table: one node index per (node, letter); 0 means no child
  logic [NODE_BITS-1:0] child_mem [SLOTS];

  state_t state, state_next;

  // control
  logic [ADDR_W-1:0]    clear_addr;
  logic [NODE_BITS-1:0] cursor;
  logic [FREE_W-1:0]    next_free;
  logic                 path_lost;
  logic                 pool_overflow;

  // request held for the walk step
  req_t                 req_op;
  logic                 req_last;
  logic                 req_active;
  logic                 req_lost;
  logic [ADDR_W-1:0]    slot;
  logic [NODE_BITS-1:0] child_rdata;

  // walk step result held for the update step
  logic                 res_last;
  status_t              res_status;

  // FSM outputs
  logic accept;
  logic clearing;
  logic step;
  logic wrap_up;

  logic                 clear_last;
  logic                 in_range;
  logic                 flags_clear;
  logic [ADDR_W-1:0]    slot_calc;

  logic [NODE_BITS-1:0] walk_target;
  logic                 walk_alloc;
  logic                 walk_lost;
  logic                 walk_ovf;
  upd_t                 walk_ctl;
  status_t              walk_status;

  logic                 child_we;
  logic [ADDR_W-1:0]    child_waddr;
  logic [NODE_BITS-1:0] child_wdata;

  logic                       bank_clear;
  logic [COUNT_OUT_W-1:0]     bank_count;

  // ---------------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  state_next = clear_last ? S_IDLE : S_CLEAR;
      S_IDLE:   state_next = start ? S_CHILD : S_IDLE;
      S_CHILD:  state_next = S_UPDATE;
      S_UPDATE: state_next = start ? S_CHILD : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy     = state inside {S_CLEAR, S_CHILD};
    accept   = start && !busy;
    clearing = (state == S_CLEAR);
    step     = (state == S_CHILD);
    wrap_up  = (state == S_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing sweep after reset
  // ---------------------------------------------------------------------------
  assign clear_last = (clear_addr == ADDR_W'(SLOTS - 1));
  assign bank_clear = clearing && (clear_addr < ADDR_W'(NODE_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (clearing && !clear_last) begin
      clear_addr <= clear_addr + ADDR_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Accept: latch the letter and read the child slot
  // ---------------------------------------------------------------------------
  assign in_range    = CMP_W'(letter) < CMP_W'(ALPHABET_SIZE);
  assign flags_clear = !path_lost && !pool_overflow;
  // slot = cursor * ALPHABET_SIZE + letter; only used when the letter is in range
  assign slot_calc   = ADDR_W'(cursor) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(letter);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op      <= req_t'(req_type);
      req_last    <= word_end;
      req_active  <= flags_clear && in_range;
      req_lost    <= flags_clear && !in_range;
      slot        <= slot_calc;
      child_rdata <= child_mem[slot_calc];
    end
  end

  // ---------------------------------------------------------------------------
  // Walk step: follow or allocate the child, pick counter work
  // ---------------------------------------------------------------------------
  always_comb begin
    walk_target = cursor;
    walk_alloc  = 1'b0;
    walk_lost   = path_lost || req_lost;
    walk_ovf    = pool_overflow;
    walk_ctl    = '0;

    if (req_active) begin
      if (req_op == REQ_INSERT) begin
        if (child_rdata == '0) begin
          if (next_free < FREE_W'(NODE_COUNT)) begin
            walk_alloc  = 1'b1;
            walk_target = next_free[NODE_BITS-1:0];
          end else begin
            walk_ovf = 1'b1;
          end
        end else begin
          walk_target = child_rdata;
        end
        walk_ctl.prefix_inc = !walk_ovf;
      end else if (child_rdata == '0) begin
        walk_lost = 1'b1;
      end else begin
        walk_target         = child_rdata;
        walk_ctl.prefix_dec = (req_op == REQ_ERASE);
      end
    end

    if (req_last && !walk_lost && !walk_ovf) begin
      case (req_op)
        REQ_INSERT: walk_ctl.end_inc    = 1'b1;
        REQ_ERASE:  walk_ctl.end_dec    = 1'b1;
        REQ_EQUAL:  walk_ctl.sel_end    = 1'b1;
        REQ_PREFIX: walk_ctl.sel_prefix = 1'b1;
        default:    walk_ctl            = '0;
      endcase
    end

    if (walk_ovf) begin
      walk_status = ST_FULL;
    end else if (walk_lost) begin
      walk_status = ST_LOST;
    end else begin
      walk_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor        <= '0;
      next_free     <= FREE_W'(1);
      path_lost     <= 1'b0;
      pool_overflow <= 1'b0;
    end else if (step) begin
      // word end sends the walk back to the root
      cursor        <= req_last ? '0 : walk_target;
      path_lost     <= !req_last && walk_lost;
      pool_overflow <= !req_last && walk_ovf;
      if (walk_alloc) begin
        next_free <= next_free + FREE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_last   <= req_last;
      res_status <= walk_status;
    end
  end

  // child table write port: sweep, or link a newly allocated node
  always_comb begin
    child_we    = clearing || (step && walk_alloc);
    child_waddr = clearing ? clear_addr : slot;
    child_wdata = clearing ? '0 : next_free[NODE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Counter bank: read during the walk step, write back in the update step
  // ---------------------------------------------------------------------------
  tpc_count_bank #(
    .NODE_COUNT (NODE_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_count_bank (
    .clk        (clk),
    .rst        (rst),
    .clear_en   (bank_clear),
    .clear_node (clear_addr[NODE_BITS-1:0]),
    .lookup     (step),
    .node       (walk_target),
    .ctl        (walk_ctl),
    .count      (bank_count)
  );

  // ---------------------------------------------------------------------------
  // Result beat
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= wrap_up && res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wrap_up) begin
      count  <= bank_count;
      status <= res_status;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `TPC_ASSERT_IMPL(a_done_after_update, clk, rst, done, $past(state == S_UPDATE))
  `TPC_ASSERT_IMPL(a_root_at_result, clk, rst, done,
                   cursor == '0 && !path_lost && !pool_overflow)
  `TPC_ASSERT_IMPL(a_pool_bound, clk, rst, 1'b1, next_free <= FREE_W'(NODE_COUNT))
  `TPC_ASSERT_NEXT(a_alloc_advances, clk, rst, step && walk_alloc,
                   next_free == $past(next_free) + FREE_W'(1))

endmodule

[src/tpc_count_bank.sv]
// Prefix and end counters in one memory with saturating read-modify-write.
module tpc_count_bank #(
  parameter int NODE_COUNT = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clear_en,
  input  logic [$clog2(NODE_COUNT)-1:0]    clear_node,
  input  logic                             lookup,
  input  logic [$clog2(NODE_COUNT)-1:0]    node,
  input  tpc_pkg::upd_t                    ctl,
  output logic [tpc_pkg::COUNT_OUT_W-1:0]  count
);
  import tpc_pkg::*;

  localparam int NODE_BITS = $clog2(NODE_COUNT);
  localparam int SAT_W     = COUNT_BITS + COUNT_OUT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // one word per node: {prefix count, end count}
  logic [2*COUNT_BITS-1:0] cnt_mem [NODE_COUNT];

  logic                  stage_valid;
  logic [NODE_BITS-1:0]  stage_node;
  upd_t                  stage_ctl;
  logic [COUNT_BITS-1:0] prefix_rd;
  logic [COUNT_BITS-1:0] end_rd;

  logic                  prefix_we;
  logic                  end_we;
  logic [COUNT_BITS-1:0] prefix_new;
  logic [COUNT_BITS-1:0] end_new;

  function automatic logic [COUNT_BITS-1:0] sat_step(input logic [COUNT_BITS-1:0] v,
                                                     input logic up);
    logic [COUNT_BITS-1:0] r;
    if (up) begin
      r = (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
    end else begin
      r = (v == '0) ? v : v - COUNT_BITS'(1);
    end
    return r;
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
    logic [SAT_W-1:0] w;
    w = SAT_W'(v);
    return (w > SAT_W'(COUNT_OUT_MAX)) ? COUNT_OUT_MAX : w[COUNT_OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= lookup;
    end
  end

  // read stage: registered read of both counters of the node
  always_ff @(posedge clk) begin
    if (lookup) begin
      stage_node           <= node;
      stage_ctl            <= ctl;
      {prefix_rd, end_rd}  <= cnt_mem[node];
    end
  end

  // a field with no work is written back unchanged
  always_comb begin
    prefix_we  = stage_valid && (stage_ctl.prefix_inc || stage_ctl.prefix_dec);
    end_we     = stage_valid && (stage_ctl.end_inc || stage_ctl.end_dec);
    prefix_new = prefix_we ? sat_step(prefix_rd, stage_ctl.prefix_inc) : prefix_rd;
    end_new    = end_we ? sat_step(end_rd, stage_ctl.end_inc) : end_rd;
  end

  always_ff @(posedge clk) begin
    if (clear_en) begin
      cnt_mem[clear_node] <= '0;
    end else if (prefix_we || end_we) begin
      cnt_mem[stage_node] <= {prefix_new, end_new};
    end
  end

  always_comb begin
    count = '0;
    if (stage_valid && stage_ctl.sel_end) begin
      count = sat_out(end_rd);
    end else if (stage_valid && stage_ctl.sel_prefix) begin
      count = sat_out(prefix_rd);
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for trie_prefix_counter: letter beats in, per-word counts checked.
module tb_top;
  import tpc_pkg::*;

  // Sizes match the block's defaults; they are passed to the instance explicitly.
  localparam int NODES     = 4096;
  localparam int LETTERS   = 26;
  localparam int CNT_BITS  = 16;
  localparam int unsigned CNT_MAX = (1 << CNT_BITS) - 1;

  // One letter beat as the sender presents it.
  typedef struct {
    req_t       op;
    logic [4:0] ltr;
    logic       last;
  } letter_beat_t;

  // One word result as the block should report it.
  typedef struct {
    logic [15:0] cnt;
    status_t     st;
  } word_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = REQ_INSERT;
  logic [4:0]  letter = '0;
  logic        word_end = 1'b0;
  logic        done;
  logic [15:0] count;
  logic [1:0]  status;

  letter_beat_t pending_beats[$];   // beats not yet put on the ports
  word_result_t awaited_results[$]; // predicted word results, oldest first

  int idle_pct   = 0;   // chance per cycle that the sender holds off
  int pushed     = 0;
  int errors     = 0;
  logic beat_taken = 1'b0;

  // Shadow trie: child links, counters, allocation pointer, walk state.
  int unsigned child_tbl[NODES*LETTERS];
  int unsigned pfx_cnt[NODES];
  int unsigned end_cnt[NODES];
  int unsigned free_node = 1;
  int unsigned cursor = 0;
  bit          lost = 1'b0;
  bit          full = 1'b0;

  trie_prefix_counter #(
    .NODE_COUNT   (NODES),
    .ALPHABET_SIZE(LETTERS),
    .COUNT_BITS   (CNT_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req_type(req_type),
    .letter  (letter),
    .word_end(word_end),
    .done    (done),
    .count   (count),
    .status  (status)
  );

  always #10 clk = ~clk;

  function automatic int unsigned sat_up(int unsigned v);
    return (v >= CNT_MAX) ? CNT_MAX : v + 1;
  endfunction

  function automatic int unsigned sat_down(int unsigned v);
    return (v == 0) ? 0 : v - 1;
  endfunction

  // Advance the shadow trie by one letter; at a word end, queue the result
  // and put the walk back at the root.
  function automatic void walk_letter(req_t op, logic [4:0] ltr, logic last);
    int unsigned slot;
    int unsigned child;
    int unsigned cnt;
    status_t     st;
    cnt = 0;
    if (!lost && !full) begin
      if (ltr >= LETTERS) begin
        lost = 1'b1;  // out-of-alphabet letter loses the path, insert too
      end else begin
        slot  = cursor * LETTERS + ltr;
        child = child_tbl[slot];
        if (op == REQ_INSERT) begin
          if (child == 0) begin
            if (free_node < NODES) begin
              child = free_node;
              free_node++;
              child_tbl[slot] = child;
            end else begin
              full = 1'b1;  // pool exhausted: rest of the word is dropped
            end
          end
          if (!full) begin
            pfx_cnt[child] = sat_up(pfx_cnt[child]);
            cursor = child;
          end
        end else if (child == 0) begin
          lost = 1'b1;
        end else begin
          if (op == REQ_ERASE) pfx_cnt[child] = sat_down(pfx_cnt[child]);
          cursor = child;
        end
      end
    end
    if (last) begin
      if (!lost && !full) begin
        case (op)
          REQ_INSERT: end_cnt[cursor] = sat_up(end_cnt[cursor]);
          REQ_ERASE:  end_cnt[cursor] = sat_down(end_cnt[cursor]);
          REQ_EQUAL:  cnt = end_cnt[cursor];
          default:    cnt = pfx_cnt[cursor];
        endcase
      end
      if (cnt > 16'hFFFF) cnt = 16'hFFFF;
      st = full ? ST_FULL : (lost ? ST_LOST : ST_OK);
      awaited_results.push_back('{cnt: cnt[15:0], st: st});
      cursor = 0;
      lost   = 1'b0;
      full   = 1'b0;
    end
  endfunction

  // Driver: new beat at the falling edge once the previous one was taken.
  // start stays high across back-to-back beats (one assignment per edge).
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req_type <= pending_beats[0].op;
        letter   <= pending_beats[0].ltr;
        word_end <= pending_beats[0].last;
        start    <= 1'b1;
        pending_beats.delete(0);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results against the oldest prediction, then predict for
  // the beat taken at this edge. A result is registered only after its beat
  // has passed the walk and update steps, so the order of the two steps here does not matter.
  always @(posedge clk) begin : monitor
    word_result_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing expected: count %0d status %0d", count, status);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (count !== want.cnt) begin
            $error("count mismatch: expected %0d, got %0d", want.cnt, count);
            errors++;
          end
          if (status !== want.st) begin
            $error("status mismatch: expected %0d, got %0d", want.st, status);
            errors++;
          end
        end
      end
      if (start && !busy) walk_letter(req_t'(req_type), letter, word_end);
      beat_taken <= start && !busy;
    end
  end

  task automatic put(req_t op, int ltr, bit last);
    pending_beats.push_back('{op: op, ltr: ltr[4:0], last: last});
    pushed++;
  endtask

  // A whole word of one operation with letters below span.
  task automatic add_word(req_t op, int len, int span);
    for (int i = 0; i < len; i++) put(op, $urandom_range(span - 1), i == len - 1);
  endtask

  // Sender pause: every beat handed over and every result back.
  task automatic drain();
    while (pending_beats.size() != 0 || start) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Mostly short words over a narrow alphabet so that lookups and erases hit
  // existing paths; some mixed-operation words and some loose noise beats.
  task automatic random_batch(int n);
    int   goal;
    int   r;
    int   len;
    int   span;
    req_t op;
    goal = pushed + n;
    while (pushed < goal) begin
      r    = $urandom_range(99);
      len  = $urandom_range(4, 1);
      span = ($urandom_range(9) == 0) ? LETTERS : 4;
      if (r < 80) begin
        op = ($urandom_range(9) < 4) ? REQ_INSERT : req_t'($urandom_range(3));
        add_word(op, len, span);
      end else if (r < 90) begin
        for (int i = 0; i < len; i++)
          put(req_t'($urandom_range(3)), $urandom_range(span - 1), i == len - 1);
      end else begin
        put(req_t'($urandom_range(3)), $urandom_range(31), $urandom_range(1));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words; the clearing sweep after reset simply holds busy high.
    put(REQ_INSERT, 0, 1);                        // "a"
    put(REQ_INSERT, 0, 0);  put(REQ_INSERT, 25, 1); // "az"
    put(REQ_EQUAL, 0, 1);                         // 1
    put(REQ_PREFIX, 0, 1);                        // 2
    put(REQ_EQUAL, 0, 0);   put(REQ_EQUAL, 25, 1);  // 1
    put(REQ_PREFIX, 1, 1);                        // missing at root
    put(REQ_PREFIX, 0, 0);  put(REQ_PREFIX, 3, 1);  // missing deeper
    put(REQ_ERASE, 0, 0);   put(REQ_ERASE, 9, 1);   // erase stops, first dec kept
    put(REQ_ERASE, 0, 1);
    put(REQ_ERASE, 0, 1);                         // both counters pinned at zero
    put(REQ_PREFIX, 0, 1);
    put(REQ_INSERT, 31, 1);                       // letter out of range
    put(REQ_INSERT, 16, 1);
    put(REQ_ERASE, 26, 1);
    put(REQ_INSERT, 5, 0);  put(REQ_PREFIX, 5, 1);  // mixed: insert then query
    put(REQ_PREFIX, 0, 0);  put(REQ_INSERT, 7, 1);  // mixed: walk then insert
    put(REQ_EQUAL, 25, 1);
    drain();

    // Random traffic under different sender gaps, with a full pause after the first.
    idle_pct = 0;
    random_batch(360);
    drain();
    idle_pct = 64;
    random_batch(360);
    idle_pct = 38;
    random_batch(360);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: clearing sweep plus every phase, several times over.
  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tpc_pkg.sv
src/tpc_count_bank.sv
src/trie_prefix_counter.sv
tb/tb_top.sv
